/* rtl/i2a_pkg.sv */
// Shared types, codes and helper functions of the integer to ASCII formatter.
package i2a_pkg;

	// Conversion codes.
	localparam int unsigned OP_W = 3;
	localparam logic [OP_W-1:0] OP_SDEC = 3'd0;
	localparam logic [OP_W-1:0] OP_UDEC = 3'd1;
	localparam logic [OP_W-1:0] OP_HEXL = 3'd2;
	localparam logic [OP_W-1:0] OP_HEXU = 3'd3;
	localparam logic [OP_W-1:0] OP_CHAR = 3'd4;
	localparam logic [OP_W-1:0] OP_PCT  = 3'd5;

	// Field sizes.
	localparam int unsigned VALUE_W      = 32;
	localparam int unsigned FWIDTH_W     = 7;
	localparam int unsigned CHAR_W       = 8;
	localparam int unsigned MAX_WIDTH_DEF = 64;

	// Digit buffer: ten decimal digits cover any 32-bit value.
	localparam int unsigned DEC_DIGITS = 10;
	localparam int unsigned HEX_DIGITS = 8;
	localparam int unsigned BCD_W      = 4 * DEC_DIGITS;
	localparam int unsigned NDIG_W     = 4;
	localparam int unsigned CNT_W      = 5;

	// ASCII characters.
	localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
	localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
	localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
	localparam logic [CHAR_W-1:0] CH_PCT   = 8'h25;
	localparam logic [CHAR_W-1:0] CH_LOWA  = 8'h61;
	localparam logic [CHAR_W-1:0] CH_UPA   = 8'h41;

	// Sequencer states.
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CONV,
		ST_TRIM,
		ST_PAD,
		ST_SIGN,
		ST_DIGIT
	} state_t;

	// One double-dabble correction: every BCD digit of five or more gets three added.
	function automatic logic [BCD_W-1:0] dabble_adjust(input logic [BCD_W-1:0] bcd);
		logic [BCD_W-1:0] res;
		res = bcd;
		for (int i = 0; i < DEC_DIGITS; i++) begin
			if (bcd[4*i +: 4] >= 4'd5) begin
				res[4*i +: 4] = bcd[4*i +: 4] + 4'd3;
			end
		end
		return res;
	endfunction

	// ASCII text of one digit, decimal or hex, in the requested case.
	function automatic logic [CHAR_W-1:0] digit_ascii(input logic [3:0] d, input logic upper);
		logic [CHAR_W-1:0] res;
		if (d < 4'd10) begin
			res = CH_ZERO + CHAR_W'(d);
		end else if (upper) begin
			res = CH_UPA + CHAR_W'(d - 4'd10);
		end else begin
			res = CH_LOWA + CHAR_W'(d - 4'd10);
		end
		return res;
	endfunction

endpackage

/* rtl/integer_to_ascii_formatter_core.sv */
// Top level of the integer to ASCII formatter: conversion sequencer and output register.
//
// Formats one request (op, value, field_width, zero_pad) as printf-style text and sends it
// one character per result, with last set on the final character. A request is handled one
// at a time: in_stall is high from acceptance until the last character has been loaded into
// the output register. Decimal requests first run a bit-serial binary to BCD conversion; every
// request then sizes its text by dropping leading zeros (up to nine), and then sends one
// character per cycle, padding included, whenever the receiver does not stall. Fields wider
// than MAX_WIDTH are capped at MAX_WIDTH. A request with an unknown code and width zero
// produces no result.
module integer_to_ascii_formatter_core #(
	parameter int unsigned MAX_WIDTH = i2a_pkg::MAX_WIDTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [i2a_pkg::OP_W-1:0]      op,
	input  logic [i2a_pkg::VALUE_W-1:0]   value,
	input  logic [i2a_pkg::FWIDTH_W-1:0]  field_width,
	input  logic                          zero_pad,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [i2a_pkg::CHAR_W-1:0]    out_char,
	output logic                          last
);
	import i2a_pkg::*;

	localparam int unsigned PAD_W = $clog2(MAX_WIDTH + 1);
	localparam logic [FWIDTH_W-1:0] WIDTH_CAP = FWIDTH_W'(MAX_WIDTH);

	state_t               state_q, state_d;
	logic [OP_W-1:0]      op_q;
	logic                 zpad_q;
	logic                 neg_q;
	logic [VALUE_W-1:0]   bin_q;
	logic [BCD_W-1:0]     bcd_q;
	logic [CNT_W-1:0]     cnt_q;
	logic [NDIG_W-1:0]    ndig_q;
	logic [PAD_W-1:0]     pad_q;
	logic [PAD_W-1:0]     width_q;
	logic                 out_valid_q;
	logic [CHAR_W-1:0]    out_char_q;
	logic                 last_q;

	logic                 accept;
	logic                 slot_free;
	logic                 trim_more;
	logic [PAD_W-1:0]     text_len;
	logic [PAD_W-1:0]     pad_calc;
	state_t               after_pad;
	logic                 emit;
	logic [CHAR_W-1:0]    emit_char;
	logic                 emit_last;
	logic [CHAR_W-1:0]    text_char;
	logic [VALUE_W-1:0]   magnitude;
	logic                 in_neg;
	logic [BCD_W-1:0]     bcd_adj;

	assign in_stall  = (state_q != ST_IDLE);
	assign accept    = in_valid && (state_q == ST_IDLE);
	assign slot_free = !out_valid_q || !out_stall;
	assign out_valid = out_valid_q;
	assign out_char  = out_char_q;
	assign last      = last_q;

	// Sign handling of a signed decimal request.
	assign in_neg    = (op == OP_SDEC) && value[VALUE_W-1];
	assign magnitude = in_neg ? (~value + VALUE_W'(1)) : value;

	// BCD digits after the add-three correction of one conversion step.
	assign bcd_adj   = dabble_adjust(bcd_q);

	// Text length, padding and the next step after padding.
	assign text_len  = PAD_W'(ndig_q) + PAD_W'(neg_q);
	assign trim_more = (ndig_q > NDIG_W'(1)) && (bcd_q[BCD_W-1 -: 4] == 4'd0);
	assign pad_calc  = (width_q > text_len) ? (width_q - text_len) : '0;
	assign after_pad = neg_q ? ST_SIGN : ((ndig_q != '0) ? ST_DIGIT : ST_IDLE);

	// Character of the text at the head of the digit buffer.
	always_comb begin
		case (op_q)
			OP_CHAR: text_char = bcd_q[BCD_W-1 -: CHAR_W];
			OP_PCT:  text_char = CH_PCT;
			default: text_char = digit_ascii(bcd_q[BCD_W-1 -: 4], op_q == OP_HEXU);
		endcase
	end

	// Next state and the character sent in this cycle.
	always_comb begin
		state_d   = state_q;
		emit      = 1'b0;
		emit_char = text_char;
		emit_last = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					state_d = (op == OP_SDEC || op == OP_UDEC) ? ST_CONV : ST_TRIM;
				end
			end
			ST_CONV: begin
				if (cnt_q == '0) begin
					state_d = ST_TRIM;
				end
			end
			ST_TRIM: begin
				if (!trim_more) begin
					state_d = (pad_calc != '0) ? ST_PAD : after_pad;
				end
			end
			ST_PAD: begin
				emit      = slot_free;
				emit_char = zpad_q ? CH_ZERO : CH_SPACE;
				emit_last = (pad_q == PAD_W'(1)) && (text_len == '0);
				if (slot_free && pad_q == PAD_W'(1)) begin
					state_d = after_pad;
				end
			end
			ST_SIGN: begin
				emit      = slot_free;
				emit_char = CH_MINUS;
				emit_last = (ndig_q == '0);
				if (slot_free) begin
					state_d = (ndig_q != '0) ? ST_DIGIT : ST_IDLE;
				end
			end
			ST_DIGIT: begin
				emit      = slot_free;
				emit_last = (ndig_q == NDIG_W'(1));
				if (slot_free && ndig_q == NDIG_W'(1)) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Request capture, bit-serial BCD conversion, zero trimming and digit shifting.
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					op_q    <= op;
					zpad_q  <= zero_pad;
					neg_q   <= in_neg;
					bin_q   <= magnitude;
					cnt_q   <= CNT_W'(VALUE_W - 1);
					width_q <= (field_width > WIDTH_CAP) ? PAD_W'(WIDTH_CAP)
						: PAD_W'(field_width);
					case (op) inside
						OP_SDEC, OP_UDEC: begin
							bcd_q  <= '0;
							ndig_q <= NDIG_W'(DEC_DIGITS);
						end
						OP_HEXL, OP_HEXU: begin
							bcd_q  <= {value, (BCD_W - VALUE_W)'(0)};
							ndig_q <= NDIG_W'(HEX_DIGITS);
						end
						OP_CHAR: begin
							bcd_q  <= {value[CHAR_W-1:0], (BCD_W - CHAR_W)'(0)};
							ndig_q <= NDIG_W'(1);
						end
						OP_PCT: begin
							bcd_q  <= '0;
							ndig_q <= NDIG_W'(1);
						end
						default: begin
							bcd_q  <= '0;
							ndig_q <= '0;
						end
					endcase
				end
			end
			ST_CONV: begin
				bcd_q <= {bcd_adj[BCD_W-2:0], bin_q[VALUE_W-1]};
				bin_q <= {bin_q[VALUE_W-2:0], 1'b0};
				cnt_q <= cnt_q - CNT_W'(1);
			end
			ST_TRIM: begin
				if (trim_more) begin
					bcd_q  <= {bcd_q[BCD_W-5:0], 4'd0};
					ndig_q <= ndig_q - NDIG_W'(1);
				end else begin
					pad_q <= pad_calc;
				end
			end
			ST_PAD: begin
				if (emit) begin
					pad_q <= pad_q - PAD_W'(1);
				end
			end
			ST_DIGIT: begin
				if (emit) begin
					bcd_q  <= {bcd_q[BCD_W-5:0], 4'd0};
					ndig_q <= ndig_q - NDIG_W'(1);
				end
			end
			default: begin
			end
		endcase
	end

	// Output register valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// Output register payload.
	always_ff @(posedge clk) begin
		if (emit) begin
			out_char_q <= emit_char;
			last_q     <= emit_last;
		end
	end

endmodule

/* rtl/i2a_checker.sv */
// Port-level assertions for the integer to ASCII formatter, bound to its top level.
module i2a_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          in_valid,
	input logic                          in_stall,
	input logic                          out_valid,
	input logic                          out_stall,
	input logic [i2a_pkg::CHAR_W-1:0]    out_char,
	input logic                          last
);
	import i2a_pkg::*;

	logic in_accept;
	assign in_accept = in_valid && !in_stall;

	// A stalled result holds its character and marker.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_char) && $stable(last))
		else $error("stalled result changed");

	// An accepted request keeps the block busy in the next cycle.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_accept |=> in_stall)
		else $error("request accepted but input not stalled afterwards");

	// While a field is still being sent, no new request is taken.
	a_no_accept_mid_field: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !last |-> in_stall)
		else $error("request taken in the middle of a field");

	// Right after a new request, the output holds nothing or the end of the previous field.
	a_clean_start: assert property (@(posedge clk) disable iff (!arst_n)
		in_accept |=> !out_valid || last)
		else $error("partial field pending after a new request");

endmodule

bind integer_to_ascii_formatter_core i2a_checker u_i2a_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_stall  (in_stall),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.out_char  (out_char),
	.last      (last)
);

/* sim/integer_to_ascii_formatter_core_test.sv */
// Self-checking testbench of the integer to ASCII formatter core with its own field predictor.
module integer_to_ascii_formatter_core_test;
	timeunit 1ns;
	timeprecision 1ps;

	import i2a_pkg::*;

	// Codes outside the package set: both give an empty text.
	localparam logic [OP_W-1:0] OP_UNKNOWN    = 3'd6;
	localparam logic [OP_W-1:0] OP_UNKNOWN_HI = 3'd7;

	localparam int unsigned FIELD_MAX   = MAX_WIDTH_DEF;
	localparam int unsigned HOLD_CYCLES = 400;
	localparam int unsigned END_TAIL    = 200;
	localparam int unsigned CYCLE_LIMIT = 1000000;
	localparam int unsigned RANDOM_PER_PHASE = 95;

	localparam logic [CHAR_W-1:0] ASCII_ZERO    = "0";
	localparam logic [CHAR_W-1:0] ASCII_SPACE   = " ";
	localparam logic [CHAR_W-1:0] ASCII_MINUS   = "-";
	localparam logic [CHAR_W-1:0] ASCII_PERCENT = "%";
	localparam logic [CHAR_W-1:0] ASCII_LOWER_A = "a";
	localparam logic [CHAR_W-1:0] ASCII_UPPER_A = "A";

	typedef struct packed {
		logic [OP_W-1:0]     code;
		logic [VALUE_W-1:0]  arg;
		logic [FWIDTH_W-1:0] width;
		logic                zpad;
	} fmt_req_t;

	typedef struct packed {
		logic [CHAR_W-1:0] ch;
		logic              last_flag;
	} fmt_char_t;

	logic                clk;
	logic                arst_n = 1'b0;
	logic                in_valid = 1'b0;
	logic                in_stall;
	logic [OP_W-1:0]     op = '0;
	logic [VALUE_W-1:0]  value = '0;
	logic [FWIDTH_W-1:0] field_width = '0;
	logic                zero_pad = 1'b0;
	logic                out_valid;
	logic                out_stall = 1'b0;
	logic [CHAR_W-1:0]   out_char;
	logic                last;

	fmt_req_t    pending_requests [$];
	fmt_char_t   expected_chars [$];
	int unsigned send_idle_pct = 0;
	int unsigned recv_idle_pct = 0;
	logic        hold_arm = 1'b0;
	int unsigned hold_left = 0;
	int unsigned cycle_count = 0;
	int unsigned requests_accepted = 0;
	int unsigned chars_checked = 0;
	int unsigned mismatch_count = 0;
	int unsigned fail_count = 0;

	integer_to_ascii_formatter_core #(
		.MAX_WIDTH(FIELD_MAX)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.op(op),
		.value(value),
		.field_width(field_width),
		.zero_pad(zero_pad),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_char(out_char),
		.last(last)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Formats one request and queues the characters the block must send for it.
	function automatic void format_request(input fmt_req_t req);
		logic [CHAR_W-1:0] text [$];
		logic [CHAR_W-1:0] digits [$];
		logic [CHAR_W-1:0] pad_ch;
		logic [VALUE_W-1:0] mag;
		logic [VALUE_W-1:0] radix;
		logic [VALUE_W-1:0] d;
		logic upper;
		int unsigned w;
		int unsigned n_pad;
		fmt_char_t item;
		mag = req.arg;
		radix = 10;
		upper = 1'b0;
		case (req.code)
			OP_SDEC, OP_UDEC, OP_HEXL, OP_HEXU: begin
				if (req.code == OP_HEXL || req.code == OP_HEXU) begin
					radix = 16;
				end
				upper = (req.code == OP_HEXU);
				if (req.code == OP_SDEC && req.arg[VALUE_W-1]) begin
					text.push_back(ASCII_MINUS);
					mag = -req.arg;
				end
				// At least one digit, even for zero.
				while (digits.size() == 0 || mag != 0) begin
					d = mag % radix;
					if (d < 10) begin
						digits.push_front(ASCII_ZERO + d[CHAR_W-1:0]);
					end else if (upper) begin
						digits.push_front(ASCII_UPPER_A + d[CHAR_W-1:0] - 8'd10);
					end else begin
						digits.push_front(ASCII_LOWER_A + d[CHAR_W-1:0] - 8'd10);
					end
					mag = mag / radix;
				end
				foreach (digits[i]) begin
					text.push_back(digits[i]);
				end
			end
			OP_CHAR: begin
				text.push_back(req.arg[CHAR_W-1:0]);
			end
			OP_PCT: begin
				text.push_back(ASCII_PERCENT);
			end
			default: begin
			end
		endcase
		// Padding goes in front of everything, the minus sign included.
		w = (req.width > FIELD_MAX) ? FIELD_MAX : req.width;
		n_pad = (w > text.size()) ? w - text.size() : 0;
		pad_ch = req.zpad ? ASCII_ZERO : ASCII_SPACE;
		for (int k = 0; k < n_pad; k++) begin
			text.push_front(pad_ch);
		end
		foreach (text[i]) begin
			item.ch = text[i];
			item.last_flag = (i == text.size() - 1);
			expected_chars.push_back(item);
		end
	endfunction

	function automatic void push_request(input logic [OP_W-1:0] code,
			input logic [VALUE_W-1:0] arg, input logic [FWIDTH_W-1:0] width,
			input logic zpad);
		fmt_req_t req;
		req.code = code;
		req.arg = arg;
		req.width = width;
		req.zpad = zpad;
		pending_requests.push_back(req);
	endfunction

	// Random request: mostly known codes, values of varied magnitude, mostly narrow fields.
	function automatic void push_random_request();
		logic [OP_W-1:0] code;
		logic [VALUE_W-1:0] arg;
		logic [FWIDTH_W-1:0] width;
		int unsigned pick;
		pick = $urandom_range(9);
		if (pick == 8) begin
			code = OP_SDEC;
		end else if (pick == 9) begin
			code = OP_UDEC;
		end else begin
			code = pick[OP_W-1:0];
		end
		case ($urandom_range(5))
			0: arg = $urandom;
			1: arg = $urandom_range(20);
			2: arg = $urandom_range(99999);
			3: arg = -$urandom_range(1, 1000);
			4: begin
				pick = $urandom_range(2);
				arg = (pick == 0) ? 32'h8000_0000
					: (pick == 1) ? 32'hFFFF_FFFF : 32'h7FFF_FFFF;
			end
			default: arg = $urandom >> $urandom_range(31);
		endcase
		pick = $urandom_range(9);
		if (pick < 7) begin
			width = FWIDTH_W'($urandom_range(12));
		end else if (pick < 9) begin
			width = FWIDTH_W'($urandom_range(13, 40));
		end else begin
			width = FWIDTH_W'($urandom_range(41, 127));
		end
		push_request(code, arg, width, 1'($urandom_range(1)));
	endfunction

	// Request driver: holds a stalled request, otherwise offers the next one or idles.
	always @(posedge clk) begin
		fmt_req_t req;
		if (arst_n) begin
			if (in_valid && !in_stall) begin
				req.code = op;
				req.arg = value;
				req.width = field_width;
				req.zpad = zero_pad;
				format_request(req);
				requests_accepted++;
			end
			if (!in_valid || !in_stall) begin
				if (pending_requests.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					req = pending_requests.pop_front();
					in_valid <= 1'b1;
					op <= req.code;
					value <= req.arg;
					field_width <= req.width;
					zero_pad <= req.zpad;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Character monitor: checks each accepted character against the oldest expectation.
	always @(posedge clk) begin
		fmt_char_t want;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				chars_checked++;
				if (expected_chars.size() == 0) begin
					fail_count++;
					mismatch_count++;
					if (mismatch_count <= 10) begin
						$display("unexpected character: char=%h last=%b", out_char, last);
					end
				end else begin
					want = expected_chars.pop_front();
					if (out_char !== want.ch || last !== want.last_flag) begin
						fail_count++;
						mismatch_count++;
						if (mismatch_count <= 10) begin
							$display({"character mismatch: expected char=%h last=%b,",
								" got char=%h last=%b"},
								want.ch, want.last_flag, out_char, last);
						end
					end
				end
			end
			out_stall <= (hold_left != 0) || ($urandom_range(99) < recv_idle_pct);
		end
	end

	// Long receiver hold-off, counted here once armed.
	always @(posedge clk) begin
		if (hold_left != 0) begin
			hold_left <= hold_left - 1;
		end else if (hold_arm) begin
			hold_left <= HOLD_CYCLES;
		end
	end

	// Run limit.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	// Waits until every request is accepted and every character has arrived.
	task automatic wait_drained();
		while (pending_requests.size() != 0 || in_valid || expected_chars.size() != 0) begin
			@(negedge clk);
		end
	endtask

	// Stimulus sequence.
	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed requests, then random ones, with sender at 35% idle and receiver at 80% idle.
		send_idle_pct = 35;
		recv_idle_pct = 80;
		push_request(OP_SDEC, 32'd0, 7'd0, 1'b0);
		push_request(OP_SDEC, 32'h8000_0000, 7'd0, 1'b0);
		push_request(OP_SDEC, -32'd5, 7'd5, 1'b1);
		push_request(OP_SDEC, -32'd5, 7'd5, 1'b0);
		push_request(OP_SDEC, 32'h7FFF_FFFF, 7'd0, 1'b0);
		push_request(OP_UDEC, 32'hFFFF_FFFF, 7'd0, 1'b1);
		push_request(OP_UDEC, 32'd0, 7'd1, 1'b1);
		push_request(OP_UDEC, 32'd1000000000, 7'd12, 1'b0);
		push_request(OP_HEXL, 32'hDEAD_BEEF, 7'd0, 1'b0);
		push_request(OP_HEXU, 32'hABCD_EF01, 7'd10, 1'b1);
		push_request(OP_HEXU, 32'd0, 7'd0, 1'b0);
		push_request(OP_HEXL, 32'h1000_0000, 7'd8, 1'b0);
		push_request(OP_CHAR, 32'h0000_0000, 7'd0, 1'b0);
		push_request(OP_CHAR, 32'hFFFF_FFFF, 7'd3, 1'b1);
		push_request(OP_CHAR, 32'h1234_5641, 7'd0, 1'b0);
		push_request(OP_PCT, 32'h5555_AAAA, 7'd0, 1'b0);
		push_request(OP_PCT, 32'd0, 7'd4, 1'b1);
		push_request(OP_UNKNOWN, 32'd77, 7'd0, 1'b0);
		push_request(OP_UNKNOWN_HI, 32'hFFFF_FFFF, 7'd3, 1'b0);
		push_request(OP_UNKNOWN, 32'd0, 7'd5, 1'b1);
		push_request(OP_SDEC, 32'h8000_0000, 7'd127, 1'b1);
		push_request(OP_UDEC, 32'd12345, 7'd64, 1'b0);
		push_request(OP_HEXL, 32'hFFFF_FFFF, 7'd65, 1'b0);
		push_request(OP_UNKNOWN_HI, 32'd3, 7'd0, 1'b1);
		push_request(OP_SDEC, 32'hAAAA_AAAA, 7'd11, 1'b1);
		for (int i = 0; i < RANDOM_PER_PHASE; i++) begin
			push_random_request();
		end
		wait_drained();

		// Receiver holds off for a long stretch while the sender keeps offering requests.
		send_idle_pct = 0;
		for (int i = 0; i < 6; i++) begin
			push_request(OP_HEXU, $urandom, 7'd20, i[0]);
		end
		hold_arm = 1'b1;
		@(negedge clk);
		hold_arm = 1'b0;
		wait_drained();

		// Sender at 80% idle, receiver at 35%.
		send_idle_pct = 80;
		recv_idle_pct = 35;
		for (int i = 0; i < RANDOM_PER_PHASE; i++) begin
			push_random_request();
		end
		wait_drained();

		// No idling on either side.
		send_idle_pct = 0;
		recv_idle_pct = 0;
		for (int i = 0; i < RANDOM_PER_PHASE; i++) begin
			push_random_request();
		end
		wait_drained();
		repeat (END_TAIL) @(negedge clk);

		if (expected_chars.size() != 0) begin
			fail_count++;
		end
		$display("Formatted %0d requests over all codes, widths and pad modes.",
			requests_accepted);
		$display("Checked %0d characters through sender idling, receiver idling, %s",
			chars_checked, "a long receiver hold-off and no idling.");
		if (fail_count == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule
